### rtl/ata_pio_pkg.sv
// Package for the ATA PIO LBA28 transfer sequencer: request and bus operation codes,
// task file offsets, sequencer phases and the command record passed from front to back.
// No dependencies.
package ata_pio_pkg;

    localparam int WORDS_PER_SECTOR  = 256;
    localparam int MAX_CHUNK_SECTORS = 255;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_STATUS = 2'd1;
    localparam logic [1:0] REQ_DATA   = 2'd2;

    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_REG_WRITE = 3'd1;
    localparam logic [2:0] OP_STAT_READ = 3'd2;
    localparam logic [2:0] OP_DATA_READ = 3'd3;
    localparam logic [2:0] OP_DATA_WR   = 3'd4;
    localparam logic [2:0] OP_BUF_FETCH = 3'd5;
    localparam logic [2:0] OP_BUF_STORE = 3'd6;

    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LBA_LO  = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI  = 3'd5;
    localparam logic [2:0] REG_HEAD    = 3'd6;
    localparam logic [2:0] REG_CMD     = 3'd7;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_READY = 3'd1;
    localparam logic [2:0] PH_SWAIT = 3'd2;
    localparam logic [2:0] PH_RD    = 3'd3;
    localparam logic [2:0] PH_WR    = 3'd4;

    localparam logic [2:0] CFG_POLL_LIMIT = 3'd0;
    localparam logic [2:0] CFG_MASTER_HD  = 3'd1;
    localparam logic [2:0] CFG_SLAVE_HD   = 3'd2;
    localparam logic [2:0] CFG_READ_OP    = 3'd3;
    localparam logic [2:0] CFG_WRITE_OP   = 3'd4;

    localparam logic [7:0] STATUS_ABSENT = 8'hFF;

    localparam logic [2:0] TL_STATUS = 3'd0;
    localparam logic [2:0] TL_READ   = 3'd1;
    localparam logic [2:0] TL_FETCH  = 3'd2;
    localparam logic [2:0] TL_FINISH = 3'd3;
    localparam logic [2:0] TL_CHUNK  = 3'd4;

    typedef struct packed {
        logic        secondary;
        logic        has_word;
        logic        word_store;
        logic [15:0] word;
        logic [23:0] idx;
        logic [2:0]  tail;
        logic        ok;
        logic [7:0]  head;
        logic [7:0]  count;
        logic [23:0] lba;
        logic [7:0]  opcode;
    } t_cmd;

endpackage

### rtl/ata_pio_front.sv
// Front part of the sequencer: configuration registers, job state and the classification
// of each request into a command record for the back part.
// Depends on ata_pio_pkg.
module ata_pio_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_accept,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_port_select,
    input  logic [31:0]         i_start_lba,
    input  logic [15:0]         i_sector_total,
    input  logic                i_is_write,
    input  logic [7:0]          i_status_byte,
    input  logic [15:0]         i_data_word,
    output logic                o_push,
    output ata_pio_pkg::t_cmd   o_cmd
);
    import ata_pio_pkg::*;

    logic [15:0] r_poll_limit;
    logic [7:0]  r_master_hd, r_slave_hd, r_read_op, r_write_op;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_port, n_port;
    logic        r_is_write, n_is_write;
    logic [27:0] r_lba, n_lba;
    logic [15:0] r_sr, n_sr;
    logic [7:0]  r_csl, n_csl;
    logic [15:0] r_sd, n_sd;
    logic [7:0]  r_wis, n_wis;
    logic [15:0] r_pc, n_pc;

    logic [15:0] pc_inc;
    logic [15:0] lim;
    logic        timeout;
    logic [7:0]  chunk;
    logic [7:0]  csl_dec;
    logic        chunk_go;
    logic        push;
    t_cmd        cmd;

    assign pc_inc  = (r_pc == 16'hFFFF) ? r_pc : r_pc + 16'd1;
    assign lim     = (r_poll_limit == 16'd0) ? 16'd1 : r_poll_limit;
    assign timeout = (pc_inc >= lim);
    assign chunk   = (r_sr < 16'(MAX_CHUNK_SECTORS)) ? r_sr[7:0] : 8'(MAX_CHUNK_SECTORS);
    assign csl_dec = r_csl - 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_port     = r_port;
        n_is_write = r_is_write;
        n_lba      = r_lba;
        n_sr       = r_sr;
        n_csl      = r_csl;
        n_sd       = r_sd;
        n_wis      = r_wis;
        n_pc       = r_pc;
        push       = 1'b0;
        chunk_go   = 1'b0;
        cmd        = '0;
        cmd.tail   = TL_STATUS;

        if (i_accept) begin
            if (r_phase == PH_IDLE && i_req_type == REQ_START) begin
                n_port     = i_port_select;
                n_lba      = i_start_lba[27:0];
                n_sr       = i_sector_total;
                n_is_write = i_is_write;
                n_csl      = 8'd0;
                n_sd       = 16'd0;
                n_wis      = 8'd0;
                n_pc       = 16'd0;
                n_phase    = PH_READY;
                push       = 1'b1;
            end else if ((r_phase == PH_READY || r_phase == PH_SWAIT)
                         && i_req_type == REQ_STATUS) begin
                n_pc = pc_inc;
                push = 1'b1;
                if (r_phase == PH_READY) begin
                    if (i_status_byte == STATUS_ABSENT || !i_status_byte[7] || timeout) begin
                        chunk_go = 1'b1;
                    end
                end else if (i_status_byte == STATUS_ABSENT) begin
                    cmd.tail = TL_FINISH;
                    n_phase  = PH_IDLE;
                end else if (!i_status_byte[7]) begin
                    if (i_status_byte[0]) begin
                        cmd.tail = TL_FINISH;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_wis = 8'd0;
                        if (r_is_write) begin
                            n_phase  = PH_WR;
                            cmd.tail = TL_FETCH;
                            cmd.idx  = {r_sd, 8'd0};
                        end else begin
                            n_phase  = PH_RD;
                            cmd.tail = TL_READ;
                        end
                    end
                end else if (timeout) begin
                    cmd.tail = TL_FINISH;
                    n_phase  = PH_IDLE;
                end
            end else if ((r_phase == PH_RD || r_phase == PH_WR) && i_req_type == REQ_DATA) begin
                push           = 1'b1;
                cmd.has_word   = 1'b1;
                cmd.word_store = (r_phase == PH_RD);
                cmd.word       = i_data_word;
                cmd.idx        = (r_phase == PH_RD) ? {r_sd, r_wis} : {r_sd, r_wis + 8'd1};
                if (r_wis == 8'(WORDS_PER_SECTOR - 1)) begin
                    n_wis = 8'd0;
                    n_sd  = r_sd + 16'd1;
                    n_csl = csl_dec;
                    if (csl_dec != 8'd0) begin
                        n_phase  = PH_SWAIT;
                        n_pc     = 16'd0;
                        cmd.tail = TL_STATUS;
                    end else begin
                        chunk_go = 1'b1;
                    end
                end else begin
                    n_wis    = r_wis + 8'd1;
                    cmd.tail = (r_phase == PH_RD) ? TL_READ : TL_FETCH;
                end
            end
        end

        if (chunk_go) begin
            if (r_sr == 16'd0) begin
                cmd.tail = TL_FINISH;
                cmd.ok   = 1'b1;
                n_phase  = PH_IDLE;
            end else begin
                cmd.tail   = TL_CHUNK;
                cmd.head   = (r_port[0] ? r_slave_hd : r_master_hd) | {4'd0, r_lba[27:24]};
                cmd.count  = chunk;
                cmd.lba    = r_lba[23:0];
                cmd.opcode = r_is_write ? r_write_op : r_read_op;
                n_csl      = chunk;
                n_sr       = r_sr - {8'd0, chunk};
                n_lba      = r_lba + {20'd0, chunk};
                n_phase    = PH_SWAIT;
                n_pc       = 16'd0;
            end
        end

        cmd.secondary = n_port[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= 16'd10000;
            r_master_hd  <= 8'hE0;
            r_slave_hd   <= 8'hF0;
            r_read_op    <= 8'h20;
            r_write_op   <= 8'h30;
            r_phase      <= PH_IDLE;
            r_port       <= 2'd0;
            r_is_write   <= 1'b0;
            r_lba        <= 28'd0;
            r_sr         <= 16'd0;
            r_csl        <= 8'd0;
            r_sd         <= 16'd0;
            r_wis        <= 8'd0;
            r_pc         <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                    CFG_MASTER_HD:  r_master_hd  <= i_cfg_data[7:0];
                    CFG_SLAVE_HD:   r_slave_hd   <= i_cfg_data[7:0];
                    CFG_READ_OP:    r_read_op    <= i_cfg_data[7:0];
                    CFG_WRITE_OP:   r_write_op   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            r_phase    <= n_phase;
            r_port     <= n_port;
            r_is_write <= n_is_write;
            r_lba      <= n_lba;
            r_sr       <= n_sr;
            r_csl      <= n_csl;
            r_sd       <= n_sd;
            r_wis      <= n_wis;
            r_pc       <= n_pc;
        end
    end

    assign o_push = push;
    assign o_cmd  = cmd;

endmodule

### rtl/ata_pio_queue.sv
// Short command queue between the front and back parts of the sequencer.
// Depends on ata_pio_pkg for the command record.
module ata_pio_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ata_pio_pkg::t_cmd   i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output ata_pio_pkg::t_cmd   o_cmd
);
    import ata_pio_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/ata_pio_back.sv
// Back part of the sequencer: expands each queued command into its bus operations and
// drives them one per cycle, while a command waits and the output is ready, through a registered output stage.
// Depends on ata_pio_pkg.
module ata_pio_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  ata_pio_pkg::t_cmd   i_cmd,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [47:0]         m_axis_tdata,
    output logic [2:0]          m_axis_tuser,
    output logic                m_axis_tlast
);
    import ata_pio_pkg::*;

    logic        r_valid;
    logic [47:0] r_tdata;
    logic [2:0]  r_tuser;
    logic        r_tlast;
    logic [2:0]  r_step;

    logic [2:0]  step;
    logic        load;
    logic [2:0]  op;
    logic [2:0]  off;
    logic [15:0] data;
    logic [23:0] idx;
    logic        done;
    logic        ok;
    logic        is_last;

    assign step = r_step + {2'd0, !i_cmd.has_word};
    assign load = !i_empty && (!r_valid || m_axis_tready);

    always_comb begin
        op      = OP_NONE;
        off     = REG_DATA;
        data    = 16'd0;
        idx     = 24'd0;
        done    = 1'b0;
        ok      = 1'b0;
        is_last = 1'b0;
        if (step == 3'd0) begin
            op   = i_cmd.word_store ? OP_BUF_STORE : OP_DATA_WR;
            data = i_cmd.word;
            idx  = i_cmd.word_store ? i_cmd.idx : 24'd0;
        end else begin
            case (i_cmd.tail)
                TL_STATUS: begin
                    op      = OP_STAT_READ;
                    off     = REG_CMD;
                    is_last = 1'b1;
                end
                TL_READ: begin
                    op      = OP_DATA_READ;
                    is_last = 1'b1;
                end
                TL_FETCH: begin
                    op      = OP_BUF_FETCH;
                    idx     = i_cmd.idx;
                    is_last = 1'b1;
                end
                TL_FINISH: begin
                    done    = 1'b1;
                    ok      = i_cmd.ok;
                    is_last = 1'b1;
                end
                TL_CHUNK: begin
                    op = OP_REG_WRITE;
                    case (step)
                        3'd1: begin
                            off  = REG_HEAD;
                            data = {8'd0, i_cmd.head};
                        end
                        3'd2: begin
                            off  = REG_COUNT;
                            data = {8'd0, i_cmd.count};
                        end
                        3'd3: begin
                            off  = REG_LBA_LO;
                            data = {8'd0, i_cmd.lba[7:0]};
                        end
                        3'd4: begin
                            off  = REG_LBA_MID;
                            data = {8'd0, i_cmd.lba[15:8]};
                        end
                        3'd5: begin
                            off  = REG_LBA_HI;
                            data = {8'd0, i_cmd.lba[23:16]};
                        end
                        3'd6: begin
                            off  = REG_CMD;
                            data = {8'd0, i_cmd.opcode};
                        end
                        default: begin
                            op      = OP_STAT_READ;
                            off     = REG_CMD;
                            is_last = 1'b1;
                        end
                    endcase
                end
                default: begin
                    is_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= {2'd0, ok, done, idx, data, off, i_cmd.secondary};
            r_tuser <= op;
            r_tlast <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_step  <= is_last ? 3'd0 : r_step + 3'd1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_pop         = load && is_last;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;
    assign m_axis_tlast  = r_tlast;

endmodule

### rtl/ata_pio_lba28_transfer_sequencer.sv
// Host-side ATA PIO engine for 28-bit LBA transfers, top level.
// The first bus operation of a request passes through the command queue and the output register.
// Throughput: a request is accepted every cycle while the command queue has room; the back
// part issues one bus operation per cycle while the output is ready; a request yields no
// bus operation when ignored, two for most data words and up to eight when one ends a chunk.
// Reset: synchronous, active low; clears job state and queue, loads register defaults.
module ata_pio_lba28_transfer_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: port_select, start_lba, sector_total, is_write, status_byte, data_word, zero pad
    input  logic [79:0] s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: secondary_channel, reg_offset, bus_data, buffer_index, done_res, success, zero pad
    output logic [47:0] m_axis_tdata,
    // tuser: bus_op
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import ata_pio_pkg::*;

    logic accept;
    logic push, pop, full, empty;
    t_cmd push_cmd, head_cmd;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    ata_pio_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_req_type     (s_axis_tuser),
        .i_port_select  (s_axis_tdata[1:0]),
        .i_start_lba    (s_axis_tdata[33:2]),
        .i_sector_total (s_axis_tdata[49:34]),
        .i_is_write     (s_axis_tdata[50]),
        .i_status_byte  (s_axis_tdata[58:51]),
        .i_data_word    (s_axis_tdata[74:59]),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    ata_pio_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    ata_pio_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
